### hw/rtl/fmsk_pkg.sv
`timescale 1ns / 1ps

package fmsk_pkg;

    // Input item kinds
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // Header constants
    localparam logic [7:0]  HDR_FIN_TEXT  = 8'h81;
    localparam logic [7:0]  HDR_MASK_BIT  = 8'h80;
    localparam logic [15:0] LEN_SHORT_MAX = 16'd125;
    localparam logic [6:0]  LEN_EXT16     = 7'd126;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic        is_start;
        logic [15:0] len;
        logic [31:0] key;
        logic [7:0]  data;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic in_frame;
    } t_front_status;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

### hw/rtl/fmsk_if.sv
`timescale 1ns / 1ps

interface fmsk_in_if ();
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] frame_length;
    logic [31:0] mask_key;
    logic [7:0]  payload_byte;

    modport source (output valid, output func, output frame_length, output mask_key,
                    output payload_byte, input ready);
    modport sink   (input valid, input func, input frame_length, input mask_key,
                    input payload_byte, output ready);
endinterface

interface fmsk_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_header;
    logic       last;

    modport source (output valid, output out_byte, output is_header, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_header, input last,
                    output ready);
endinterface

### hw/rtl/fmsk_front.sv
`timescale 1ns / 1ps

module fmsk_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    fmsk_in_if.sink                i_in,
    output logic                   o_push_valid,
    output fmsk_pkg::t_cmd         o_push_cmd,
    input  logic                   i_push_ready,
    output fmsk_pkg::t_front_status o_status
);

    logic [15:0] r_bytes_left, n_bytes_left;
    logic [31:0] r_held_mask, n_held_mask;
    logic [1:0]  r_mask_phase, n_mask_phase;
    logic        accept;
    logic        in_frame;
    logic [7:0]  mask_byte;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;
    assign in_frame   = (r_bytes_left != 16'd0);

    always_comb begin
        case (r_mask_phase)
            2'd0:    mask_byte = r_held_mask[31:24];
            2'd1:    mask_byte = r_held_mask[23:16];
            2'd2:    mask_byte = r_held_mask[15:8];
            default: mask_byte = r_held_mask[7:0];
        endcase
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_held_mask  = r_held_mask;
        n_mask_phase = r_mask_phase;
        o_push_valid = 1'b0;
        o_push_cmd.is_start = (i_in.func == fmsk_pkg::FUNC_START);
        o_push_cmd.len      = i_in.frame_length;
        o_push_cmd.key      = i_in.mask_key;
        o_push_cmd.data     = i_in.payload_byte ^ mask_byte;
        o_push_cmd.last     = (r_bytes_left == 16'd1);
        if (accept) begin
            if (i_in.func == fmsk_pkg::FUNC_START) begin
                // restart: abandon any open frame
                o_push_valid = 1'b1;
                n_bytes_left = i_in.frame_length;
                n_held_mask  = i_in.mask_key;
                n_mask_phase = 2'd0;
            end else if (in_frame) begin
                o_push_valid = 1'b1;
                n_bytes_left = r_bytes_left - 16'd1;
                n_mask_phase = r_mask_phase + 2'd1;
            end
            // payload outside a frame: drop
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 16'd0;
            r_held_mask  <= 32'd0;
            r_mask_phase <= 2'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_held_mask  <= n_held_mask;
            r_mask_phase <= n_mask_phase;
        end
    end

    assign o_status.in_frame = in_frame;

endmodule

### hw/rtl/fmsk_fifo.sv
`timescale 1ns / 1ps

module fmsk_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fmsk_pkg::t_cmd        i_push_cmd,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output fmsk_pkg::t_cmd        o_pop_cmd,
    input  logic                  i_pop,
    output fmsk_pkg::t_fifo_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fmsk_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             full, empty, do_push, do_pop;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign do_push = i_push && !full;
    assign do_pop  = i_pop && !empty;

    assign o_push_ready = !full;
    assign o_pop_valid  = !empty;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_status.full  = full;
    assign o_status.empty = empty;

endmodule

### hw/rtl/fmsk_back.sv
`timescale 1ns / 1ps

module fmsk_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  fmsk_pkg::t_cmd i_head,
    output logic           o_pop,
    fmsk_out_if.source     o_out
);

    typedef enum logic [2:0] {
        ST_OPCODE,
        ST_LEN,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_KEY0,
        ST_KEY1,
        ST_KEY2,
        ST_KEY3
    } t_step;

    t_step      r_step, n_step;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_hdr, n_hdr;
    logic       r_last, n_last;
    logic       load, long_len;

    assign load     = !r_valid || o_out.ready;
    assign long_len = (i_head.len > fmsk_pkg::LEN_SHORT_MAX);

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid && !o_out.ready;
        n_byte  = r_byte;
        n_hdr   = r_hdr;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (i_head_valid && load) begin
            n_valid = 1'b1;
            if (!i_head.is_start) begin
                n_byte = i_head.data;
                n_hdr  = 1'b0;
                n_last = i_head.last;
                o_pop  = 1'b1;
            end else begin
                n_hdr  = 1'b1;
                n_last = 1'b0;
                case (r_step)
                    ST_OPCODE: begin
                        n_byte = fmsk_pkg::HDR_FIN_TEXT;
                        n_step = ST_LEN;
                    end
                    ST_LEN: begin
                        n_byte = fmsk_pkg::HDR_MASK_BIT |
                                 {1'b0, long_len ? fmsk_pkg::LEN_EXT16 : i_head.len[6:0]};
                        n_step = long_len ? ST_LEN_HI : ST_KEY0;
                    end
                    ST_LEN_HI: begin
                        n_byte = i_head.len[15:8];
                        n_step = ST_LEN_LO;
                    end
                    ST_LEN_LO: begin
                        n_byte = i_head.len[7:0];
                        n_step = ST_KEY0;
                    end
                    ST_KEY0: begin
                        n_byte = i_head.key[31:24];
                        n_step = ST_KEY1;
                    end
                    ST_KEY1: begin
                        n_byte = i_head.key[23:16];
                        n_step = ST_KEY2;
                    end
                    ST_KEY2: begin
                        n_byte = i_head.key[15:8];
                        n_step = ST_KEY3;
                    end
                    ST_KEY3: begin
                        // empty frame ends on the last key byte
                        n_byte = i_head.key[7:0];
                        n_last = (i_head.len == 16'd0);
                        n_step = ST_OPCODE;
                        o_pop  = 1'b1;
                    end
                    default: begin
                        n_step = ST_OPCODE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_OPCODE;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
        r_byte <= n_byte;
        r_hdr  <= n_hdr;
        r_last <= n_last;
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.is_header = r_hdr;
    assign o_out.last      = r_last;

endmodule

### hw/rtl/websocket_client_frame_masker.sv
`timescale 1ns / 1ps

// Masked client WebSocket text frame builder.
// Input channel i_in: one word is either a start (func 0: frame_length, mask_key)
// or one payload byte (func 1). Output channel o_out: one frame byte per word,
// flagged is_header for header and mask key bytes, and last on the final byte.
// A start word yields 6 bytes (length up to 125) or 8 bytes (16-bit length form);
// each payload word inside a frame yields one masked byte. Payload words outside
// a frame are dropped; a start inside a frame abandons the old frame at once.
// The edge that takes an input word writes it into the command queue; the back end
// then loads the first output byte from the queue head into its output register.
// Throughput: payload bytes pass one per cycle while the receiver holds ready; a start
// occupies the output register for its 6 or 8 header bytes on the single output byte lane.
// The front end classifies and masks words and updates frame state at accept;
// a FIFO_DEPTH-entry command queue decouples it from the back end, which expands
// starts into header bytes. i_in.ready drops only while the queue is full, so
// when the receiver stalls the queue fills and input is held off after that.
// Reset (synchronous, active low) empties the queue, clears frame state and
// drops any byte waiting in the output register.
module websocket_client_frame_masker #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fmsk_in_if.sink    i_in,
    fmsk_out_if.source o_out
);

    logic                    push_valid, push_ready;
    fmsk_pkg::t_cmd          push_cmd;
    logic                    head_valid, pop;
    fmsk_pkg::t_cmd          head_cmd;
    fmsk_pkg::t_front_status front_status;
    fmsk_pkg::t_fifo_status  fifo_status;

    // Classify, mask payload, track frame state
    fmsk_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready),
        .o_status     (front_status)
    );

    // Hold commands between the two halves
    fmsk_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (head_valid),
        .o_pop_cmd    (head_cmd),
        .i_pop        (pop),
        .o_status     (fifo_status)
    );

    // Expand commands into output bytes
    fmsk_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // A payload word taken outside a frame must not reach the queue
    a_drop_outside_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.func == fmsk_pkg::FUNC_PAYLOAD) &&
         !front_status.in_frame) |-> !push_valid)
        else $error("payload outside a frame was queued");

    // A taken start opens a frame exactly when its length is nonzero
    a_start_opens_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.func == fmsk_pkg::FUNC_START)) |=>
        (front_status.in_frame == ($past(i_in.frame_length) != 16'd0)))
        else $error("frame state does not follow the start length");

    // Queue status stays consistent
    a_queue_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_status.full && fifo_status.empty) && (head_valid == !fifo_status.empty))
        else $error("command queue status inconsistent");

endmodule

### sim/websocket_client_frame_masker_tb.sv
`timescale 1ns / 1ps

module websocket_client_frame_masker_tb;

    // Generous ceiling: far beyond the slowest legal run with heavy idling
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to wait after the last frame byte has come out
    localparam int TAIL_CYCLES = 8;

    // One frame byte as the output channel presents it
    typedef struct packed {
        logic [7:0] value;
        logic       hdr;
        logic       lst;
    } t_frame_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fmsk_in_if  in_ch ();
    fmsk_out_if out_ch ();

    websocket_client_frame_masker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Frame state tracked alongside the block
    logic [15:0] payload_left;
    logic [31:0] frame_key;
    logic [1:0]  key_index;

    t_frame_byte frame_bytes_due[$];

    int send_idle_pct;
    int recv_stall_pct;
    int words_counted;
    int fail_count;
    int cycle_count;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: drop ready at random, at the rate of the current phase
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Work out the frame bytes that one accepted word produces and queue them.
    // A start always rebuilds the header, abandoning any open frame.
    task automatic predict_frame_bytes(input logic func, input logic [15:0] len,
                                       input logic [31:0] key, input logic [7:0] data,
                                       output bit dropped);
        t_frame_byte fb;
        logic [7:0]  key_byte;
        dropped = 1'b0;
        if (func == fmsk_pkg::FUNC_START) begin
            frame_bytes_due.push_back('{fmsk_pkg::HDR_FIN_TEXT, 1'b1, 1'b0});
            if (len <= fmsk_pkg::LEN_SHORT_MAX) begin
                frame_bytes_due.push_back('{fmsk_pkg::HDR_MASK_BIT | len[7:0], 1'b1, 1'b0});
            end else begin
                frame_bytes_due.push_back('{fmsk_pkg::HDR_MASK_BIT |
                                            {1'b0, fmsk_pkg::LEN_EXT16}, 1'b1, 1'b0});
                frame_bytes_due.push_back('{len[15:8], 1'b1, 1'b0});
                frame_bytes_due.push_back('{len[7:0], 1'b1, 1'b0});
            end
            // Key bytes go out first byte first; an empty frame ends on the last one
            for (int k = 0; k < 4; k++) begin
                fb.value = key[31 - 8 * k -: 8];
                fb.hdr   = 1'b1;
                fb.lst   = (k == 3) && (len == 16'd0);
                frame_bytes_due.push_back(fb);
            end
            payload_left = len;
            frame_key    = key;
            key_index    = 2'd0;
        end else if (payload_left == 16'd0) begin
            // Stray payload byte outside a frame: nothing comes out
            dropped = 1'b1;
        end else begin
            key_byte     = frame_key[31 - 8 * key_index -: 8];
            payload_left = payload_left - 16'd1;
            key_index    = key_index + 2'd1;
            frame_bytes_due.push_back('{data ^ key_byte, 1'b0, payload_left == 16'd0});
        end
    endtask

    // Offer one word on the input channel, idling first at the phase rate.
    // Called and returning at a falling edge; valid stays high for a following word.
    task automatic send_word(input logic func, input logic [15:0] len,
                             input logic [31:0] key, input logic [7:0] data);
        bit dropped;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.func         = func;
        in_ch.frame_length = len;
        in_ch.mask_key     = key;
        in_ch.payload_byte = data;
        // Hold the word until the block takes it
        do @(posedge i_clk); while (!in_ch.ready);
        predict_frame_bytes(func, len, key, data, dropped);
        if (!dropped)
            words_counted++;
        @(negedge i_clk);
    endtask

    // Unused fields carry random noise that the block must ignore
    task automatic send_start(input logic [15:0] len, input logic [31:0] key);
        send_word(fmsk_pkg::FUNC_START, len, key, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] data);
        send_word(fmsk_pkg::FUNC_PAYLOAD, 16'($urandom), $urandom, data);
    endtask

    task automatic wait_drained();
        while (frame_bytes_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Check every output word against the oldest expected frame byte
    always @(posedge i_clk) begin : check_frame_bytes
        t_frame_byte due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected frame byte %h (is_header %b, last %b)",
                       out_ch.out_byte, out_ch.is_header, out_ch.last);
                fail_count++;
            end else begin
                due = frame_bytes_due.pop_front();
                if (out_ch.out_byte !== due.value) begin
                    $error("out_byte: expected %h, actual %h", due.value, out_ch.out_byte);
                    fail_count++;
                end
                if (out_ch.is_header !== due.hdr) begin
                    $error("is_header: expected %b, actual %b", due.hdr, out_ch.is_header);
                    fail_count++;
                end
                if (out_ch.last !== due.lst) begin
                    $error("last: expected %b, actual %b", due.lst, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Extremes, empty frames, stray payload, abandoned frames, key phase wrap
    task automatic test_special_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_start(16'd0, 32'hFFFF_FFFF);      // empty frame, last on final key byte
        send_payload(8'h00);                   // stray, dropped
        send_payload(8'hFF);
        send_start(16'd1, 32'h0000_0000);
        send_payload(8'hFF);
        send_start(16'd125, 32'hA5C3_0FF0);    // longest short-length form
        send_payload(8'h00);
        send_payload(8'hFF);
        send_start(16'd126, 32'h1234_5678);    // shortest 16-bit length form, abandons
        send_payload(8'h5A);
        send_start(16'hFFFF, 32'hFFFF_FFFF);   // largest length, abandoned below
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h80);
        send_payload(8'h7F);
        send_start(16'd5, 32'h8001_FE7F);      // key index wraps on the fifth byte
        send_payload(8'h11);
        send_payload(8'h22);
        send_payload(8'h33);
        send_payload(8'h44);
        send_payload(8'h55);
        send_payload(8'hAA);                   // right after a frame ends, dropped
        send_start(16'd0, 32'h0000_0000);
        send_start(16'd2, 32'hC0FF_EE00);
        send_payload(8'h01);
        send_payload(8'h02);
    endtask

    // Mostly complete frames with random content; some cut short by the next
    // start, some followed by stray payload bytes. The last frame of a phase is
    // cut short once the word budget is spent.
    task automatic run_random_frames(input int n_words);
        int          target;
        int          sel;
        int          n_payload;
        logic [15:0] len;
        target = words_counted + n_words;
        while (words_counted < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                len = 16'($urandom_range(0, 12));
            else if (sel < 70)
                len = 16'($urandom_range(120, 131));
            else if (sel < 88)
                len = 16'($urandom_range(13, 60));
            else
                len = 16'($urandom);
            send_start(len, $urandom);
            if (len > 200)
                n_payload = $urandom_range(0, 6);
            else if ($urandom_range(0, 99) < 15)
                n_payload = $urandom_range(0, len);
            else
                n_payload = len;
            if (n_payload > target - words_counted)
                n_payload = target - words_counted;
            for (int i = 0; i < n_payload; i++)
                send_payload(8'($urandom));
            if ($urandom_range(0, 99) < 20)
                repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
        end
    endtask

    task automatic test_no_idling();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_frames(70);
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        run_random_frames(60);
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        run_random_frames(60);
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        run_random_frames(60);
    endtask

    // Hold off the sender until the block has emptied completely, then resume
    task automatic test_pause_until_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 38;
        send_start(16'd6, $urandom);
        send_payload(8'($urandom));
        send_payload(8'($urandom));
        in_ch.valid = 1'b0;
        wait_drained();
        for (int i = 0; i < 4; i++)
            send_payload(8'($urandom));
        send_start(16'd300, $urandom);
        in_ch.valid = 1'b0;
        wait_drained();
        send_payload(8'($urandom));
        send_start(16'd0, $urandom);
    endtask

    initial begin
        payload_left       = 16'd0;
        frame_key          = 32'd0;
        key_index          = 2'd0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        words_counted      = 0;
        fail_count         = 0;
        cycle_count        = 0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.func         = fmsk_pkg::FUNC_START;
        in_ch.frame_length = 16'd0;
        in_ch.mask_key     = 32'd0;
        in_ch.payload_byte = 8'd0;
        out_ch.ready       = 1'b0;

        // Hold reset, then release it at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_special_cases();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_pause_until_drained();

        in_ch.valid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && frame_bytes_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (frame_bytes_due.size() != 0)
                $error("%0d frame bytes never came out", frame_bytes_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
